// ===== src/fse_pkg.sv =====
// Shared constants, types and helper functions of the frame statistics engine.
package fse_pkg;

   localparam int CFG_W     = 11;
   localparam int PIX_W     = 8;
   localparam int CNT_W     = 21;
   localparam int SUM_W     = 28;
   localparam int HASH_W    = 32;
   localparam int QUO_W     = 8;
   localparam int CSR_IDX_W = 2;

   localparam int DEF_MAX_WIDTH     = 1024;
   localparam int DEF_MAX_HEIGHT    = 1024;
   localparam int DEF_BORDER_MARGIN = 8;

   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

   localparam logic [CFG_W-1:0]  WIDTH_RESET  = 11'd640;
   localparam logic [CFG_W-1:0]  HEIGHT_RESET = 11'd480;
   localparam logic [HASH_W-1:0] HASH_BASIS   = 32'd2166136261;
   localparam logic [HASH_W-1:0] HASH_PRIME   = 32'd16777619;
   localparam logic [PIX_W-1:0]  BRIGHT_LEVEL = 8'd128;
   localparam logic [PIX_W-1:0]  PIX_MAX      = 8'd255;

   typedef struct packed {
      logic take;
      logic div_load;
      logic div_step;
      logic out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic end_frame;
   } dp_status_type;

   function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] hash,
                                                  input logic [PIX_W-1:0] pix);
      logic [HASH_W-1:0] mixed;
      mixed = hash ^ {{(HASH_W-PIX_W){1'b0}}, pix};
      return HASH_W'(mixed * HASH_PRIME);
   endfunction

endpackage

// ===== src/fse_div.sv =====
// Restoring divider for the frame mean: a load, then one quotient bit per step.
module fse_div #(
   parameter int PW = 20
) (
   input  logic                      clock,
   input  logic                      load,
   input  logic                      step,
   input  logic [fse_pkg::SUM_W-1:0] dividend,
   input  logic [PW-1:0]             divisor,
   output logic [fse_pkg::QUO_W-1:0] mean
);

   localparam int DW = (fse_pkg::SUM_W > PW + fse_pkg::QUO_W) ?
                       fse_pkg::SUM_W : PW + fse_pkg::QUO_W;

   logic [fse_pkg::SUM_W-1:0] rem_ff, rem_in;
   logic [DW-1:0]             dsh_ff, dsh_in;
   logic [fse_pkg::QUO_W-1:0] quo_ff, quo_in;
   logic                      sat_ff, sat_in;
   logic                      ge;
   logic [DW-1:0]             diff;

   always_comb begin
      ge     = DW'(rem_ff) >= dsh_ff;
      diff   = DW'(rem_ff) - dsh_ff;
      rem_in = rem_ff;
      dsh_in = dsh_ff;
      quo_in = quo_ff;
      sat_in = sat_ff;
      if (load) begin
         rem_in = dividend;
         dsh_in = DW'(divisor) << (fse_pkg::QUO_W - 1);
         quo_in = '0;
         sat_in = DW'(dividend) >= (DW'(divisor) << fse_pkg::QUO_W);
      end else if (step) begin
         rem_in = ge ? diff[fse_pkg::SUM_W-1:0] : rem_ff;
         dsh_in = dsh_ff >> 1;
         quo_in = {quo_ff[fse_pkg::QUO_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      quo_ff <= quo_in;
      sat_ff <= sat_in;
   end

   assign mean = sat_ff ? '1 : quo_ff;

endmodule

// ===== src/fse_dp.sv =====
// Datapath: size registers, position counters, frame accumulators, snapshot and output registers.
module fse_dp #(
   parameter int MAX_WIDTH     = fse_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT    = fse_pkg::DEF_MAX_HEIGHT,
   parameter int BORDER_MARGIN = fse_pkg::DEF_BORDER_MARGIN
) (
   input  logic                          clock,
   input  logic                          reset,
   input  fse_pkg::ctrl_cmd_type         cmd,
   output fse_pkg::dp_status_type        sts,
   input  logic                          csr_write,
   input  logic [fse_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [fse_pkg::CFG_W-1:0]     csr_wdata,
   input  logic [fse_pkg::PIX_W-1:0]     req_pixel,
   output logic [fse_pkg::PIX_W-1:0]     rsp_min_value,
   output logic [fse_pkg::PIX_W-1:0]     rsp_max_value,
   output logic [fse_pkg::PIX_W-1:0]     rsp_mean_value,
   output logic [fse_pkg::CNT_W-1:0]     rsp_nonzero_count,
   output logic [fse_pkg::CNT_W-1:0]     rsp_bright_count,
   output logic [fse_pkg::CNT_W-1:0]     rsp_border_nonzero_count,
   output logic [fse_pkg::CNT_W-1:0]     rsp_interior_nonzero_count,
   output logic [fse_pkg::HASH_W-1:0]    rsp_fnv_checksum
);

   localparam int WW  = $clog2(MAX_WIDTH + 1);
   localparam int HW  = $clog2(MAX_HEIGHT + 1);
   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int RW  = $clog2(MAX_HEIGHT);
   localparam int PW  = WW + HW;
   localparam int SW  = (WW > HW) ? WW : HW;
   localparam int SW2 = (SW > fse_pkg::CFG_W) ? SW : fse_pkg::CFG_W;
   localparam int EW  = SW2 + 8;

   logic [fse_pkg::CFG_W-1:0]  width_ff, height_ff;
   logic [WW-1:0]              w_sz;
   logic [HW-1:0]              h_sz;
   logic [PW-1:0]              prod_ff;

   logic [CW-1:0]              col_ff, col_in;
   logic [RW-1:0]              row_ff, row_in;
   logic [EW-1:0]              x_e, y_e, w_e, h_e, m_e;
   logic                       border, end_line, end_frame, nonzero, bright;

   logic [fse_pkg::PIX_W-1:0]  min_ff, min_in, max_ff, max_in;
   logic [fse_pkg::SUM_W-1:0]  sum_ff, sum_in;
   logic [fse_pkg::HASH_W-1:0] hash_ff, hash_in;
   logic [fse_pkg::CNT_W-1:0]  nz_ff, nz_in, br_ff, br_in, bd_ff, bd_in, in_ff, in_in;

   logic [fse_pkg::PIX_W-1:0]  snap_min_ff, snap_max_ff;
   logic [fse_pkg::SUM_W-1:0]  snap_sum_ff;
   logic [fse_pkg::HASH_W-1:0] snap_hash_ff;
   logic [fse_pkg::CNT_W-1:0]  snap_nz_ff, snap_br_ff, snap_bd_ff, snap_in_ff;
   logic [fse_pkg::QUO_W-1:0]  mean;

   // clamp sizes: zero reads as one, oversize saturates
   always_comb begin
      if (width_ff == '0) begin
         w_sz = WW'(1);
      end else if (EW'(width_ff) > EW'(MAX_WIDTH)) begin
         w_sz = WW'(MAX_WIDTH);
      end else begin
         w_sz = WW'(width_ff);
      end
      if (height_ff == '0) begin
         h_sz = HW'(1);
      end else if (EW'(height_ff) > EW'(MAX_HEIGHT)) begin
         h_sz = HW'(MAX_HEIGHT);
      end else begin
         h_sz = HW'(height_ff);
      end
   end

   always_comb begin
      x_e       = EW'(col_ff);
      y_e       = EW'(row_ff);
      w_e       = EW'(w_sz);
      h_e       = EW'(h_sz);
      m_e       = EW'(BORDER_MARGIN);
      border    = (x_e < m_e) || (y_e < m_e) || (x_e + m_e >= w_e) || (y_e + m_e >= h_e);
      end_line  = x_e + EW'(1) >= w_e;
      end_frame = end_line && (y_e + EW'(1) >= h_e);
      nonzero   = req_pixel != '0;
      bright    = req_pixel >= fse_pkg::BRIGHT_LEVEL;
   end

   assign sts.end_frame = end_frame;

   always_comb begin
      min_in  = (req_pixel < min_ff) ? req_pixel : min_ff;
      max_in  = (req_pixel > max_ff) ? req_pixel : max_ff;
      sum_in  = sum_ff + fse_pkg::SUM_W'(req_pixel);
      hash_in = fse_pkg::fnv_step(hash_ff, req_pixel);
      nz_in   = nz_ff + fse_pkg::CNT_W'(nonzero);
      br_in   = br_ff + fse_pkg::CNT_W'(bright);
      bd_in   = bd_ff + fse_pkg::CNT_W'(nonzero && border);
      in_in   = in_ff + fse_pkg::CNT_W'(nonzero && !border);
      if (end_line) begin
         col_in = '0;
         row_in = row_ff + RW'(1);
      end else begin
         col_in = col_ff + CW'(1);
         row_in = row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= fse_pkg::WIDTH_RESET;
         height_ff <= fse_pkg::HEIGHT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            fse_pkg::REG_FRAME_WIDTH:  width_ff  <= csr_wdata;
            fse_pkg::REG_FRAME_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= PW'(w_sz) * PW'(h_sz);
   end

   always_ff @(posedge clock) begin
      if (reset || (cmd.take && end_frame)) begin
         col_ff  <= '0;
         row_ff  <= '0;
         min_ff  <= fse_pkg::PIX_MAX;
         max_ff  <= '0;
         sum_ff  <= '0;
         hash_ff <= fse_pkg::HASH_BASIS;
         nz_ff   <= '0;
         br_ff   <= '0;
         bd_ff   <= '0;
         in_ff   <= '0;
      end else if (cmd.take) begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         min_ff  <= min_in;
         max_ff  <= max_in;
         sum_ff  <= sum_in;
         hash_ff <= hash_in;
         nz_ff   <= nz_in;
         br_ff   <= br_in;
         bd_ff   <= bd_in;
         in_ff   <= in_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take && end_frame) begin
         snap_min_ff  <= min_in;
         snap_max_ff  <= max_in;
         snap_sum_ff  <= sum_in;
         snap_hash_ff <= hash_in;
         snap_nz_ff   <= nz_in;
         snap_br_ff   <= br_in;
         snap_bd_ff   <= bd_in;
         snap_in_ff   <= in_in;
      end
   end

   fse_div #(
      .PW(PW)
   ) u_div (
      .clock    (clock),
      .load     (cmd.div_load),
      .step     (cmd.div_step),
      .dividend (snap_sum_ff),
      .divisor  (prod_ff),
      .mean     (mean)
   );

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_min_value              <= snap_min_ff;
         rsp_max_value              <= snap_max_ff;
         rsp_mean_value             <= mean;
         rsp_nonzero_count          <= snap_nz_ff;
         rsp_bright_count           <= snap_br_ff;
         rsp_border_nonzero_count   <= snap_bd_ff;
         rsp_interior_nonzero_count <= snap_in_ff;
         rsp_fnv_checksum           <= snap_hash_ff;
      end
   end

endmodule

// ===== src/fse_ctrl.sv =====
// Controller: pixel intake, mean division sequence and output register handoff.
module fse_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  fse_pkg::dp_status_type sts,
   output fse_pkg::ctrl_cmd_type  cmd
);

   localparam int STEP_W = $clog2(fse_pkg::QUO_W);

   localparam logic [1:0] ST_RUN  = 2'd0;
   localparam logic [1:0] ST_LOAD = 2'd1;
   localparam logic [1:0] ST_STEP = 2'd2;
   localparam logic [1:0] ST_HOLD = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_free;

   assign req_stall = reset || (state_ff != ST_RUN);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      cmd          = '0;
      cmd.take     = req_valid && !req_stall;
      unique case (state_ff)
         ST_RUN: begin
            if (cmd.take && sts.end_frame) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.div_load = 1'b1;
            step_in      = '0;
            state_in     = ST_STEP;
         end
         ST_STEP: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(fse_pkg::QUO_W - 1)) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_RUN;
            end
         end
         default: state_in = ST_RUN;
      endcase
      priority if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== src/frame_statistics_engine.sv =====
// Top level of the frame statistics engine: controller and datapath.
//
//   channel  direction  handshake              beat contents
//   req_     in         req_valid / req_stall  one 8-bit pixel in raster order
//   rsp_     out        rsp_valid / rsp_stall  per-frame statistics, mean and checksum
//   csr_     in         csr_valid / csr_ready  register index and 11-bit size value
//
// Pixels are taken one per cycle inside a frame.
// After the last pixel of a frame req_stall stays high while the controller loads the mean
// divider, runs eight restoring steps that yield the 8-bit quotient, and moves the result into
// the output register once that register is free.
// A waiting result beat does not stall pixels of the next frame; only a second frame end does.
// Reset is synchronous; it sets the frame size to 640 by 480 and clears the running frame statistics.
module frame_statistics_engine #(
   parameter int MAX_WIDTH     = fse_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT    = fse_pkg::DEF_MAX_HEIGHT,
   parameter int BORDER_MARGIN = fse_pkg::DEF_BORDER_MARGIN
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [fse_pkg::PIX_W-1:0]     req_pixel,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [fse_pkg::PIX_W-1:0]     rsp_min_value,
   output logic [fse_pkg::PIX_W-1:0]     rsp_max_value,
   output logic [fse_pkg::PIX_W-1:0]     rsp_mean_value,
   output logic [fse_pkg::CNT_W-1:0]     rsp_nonzero_count,
   output logic [fse_pkg::CNT_W-1:0]     rsp_bright_count,
   output logic [fse_pkg::CNT_W-1:0]     rsp_border_nonzero_count,
   output logic [fse_pkg::CNT_W-1:0]     rsp_interior_nonzero_count,
   output logic [fse_pkg::HASH_W-1:0]    rsp_fnv_checksum,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [fse_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [fse_pkg::CFG_W-1:0]     csr_wdata
);

   fse_pkg::ctrl_cmd_type  cmd;
   fse_pkg::dp_status_type sts;

   assign csr_ready = !reset;

   fse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   fse_dp #(
      .MAX_WIDTH     (MAX_WIDTH),
      .MAX_HEIGHT    (MAX_HEIGHT),
      .BORDER_MARGIN (BORDER_MARGIN)
   ) u_dp (
      .clock                      (clock),
      .reset                      (reset),
      .cmd                        (cmd),
      .sts                        (sts),
      .csr_write                  (csr_valid && csr_ready),
      .csr_index                  (csr_index),
      .csr_wdata                  (csr_wdata),
      .req_pixel                  (req_pixel),
      .rsp_min_value              (rsp_min_value),
      .rsp_max_value              (rsp_max_value),
      .rsp_mean_value             (rsp_mean_value),
      .rsp_nonzero_count          (rsp_nonzero_count),
      .rsp_bright_count           (rsp_bright_count),
      .rsp_border_nonzero_count   (rsp_border_nonzero_count),
      .rsp_interior_nonzero_count (rsp_interior_nonzero_count),
      .rsp_fnv_checksum           (rsp_fnv_checksum)
   );

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid || !rsp_stall))
      else $error("output register loaded while a beat waits");

   a_frame_end_stalls: assert property (@(posedge clock) disable iff (reset)
      (cmd.take && sts.end_frame) |=> req_stall)
      else $error("pixel intake not held after frame end");

   a_load_shows_beat: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid)
      else $error("loaded result not presented");

   a_divide_only_stalled: assert property (@(posedge clock) disable iff (reset)
      (cmd.div_load || cmd.div_step) |-> (req_stall && !cmd.take))
      else $error("pixel taken during mean division");

endmodule

// ===== test/frame_statistics_engine_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for frame_statistics_engine: random frames in, per-frame statistics checked.
module frame_statistics_engine_tb;

   localparam int MARGIN          = fse_pkg::DEF_BORDER_MARGIN;
   localparam int SETTLE_CYCLES   = 24;
   localparam int QUIET_LIMIT     = 5000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int RANDOM_PIXELS   = 1700;
   localparam int BIG_FRAME       = 256;
   localparam int MAX_REPORTS     = 10;

   localparam logic [fse_pkg::CSR_IDX_W-1:0] REG_SPARE0 = 2'd2;
   localparam logic [fse_pkg::CSR_IDX_W-1:0] REG_SPARE1 = 2'd3;

   typedef struct packed {
      logic [fse_pkg::PIX_W-1:0]  min_value;
      logic [fse_pkg::PIX_W-1:0]  max_value;
      logic [fse_pkg::PIX_W-1:0]  mean_value;
      logic [fse_pkg::CNT_W-1:0]  nonzero_count;
      logic [fse_pkg::CNT_W-1:0]  bright_count;
      logic [fse_pkg::CNT_W-1:0]  border_nonzero_count;
      logic [fse_pkg::CNT_W-1:0]  interior_nonzero_count;
      logic [fse_pkg::HASH_W-1:0] fnv_checksum;
   } frame_stats_type;

   typedef enum int {FILL_NOISE, FILL_SPARSE, FILL_BRIGHT, FILL_WHITE, FILL_BLACK} fill_type;

   function automatic int unsigned clamp_size(logic [fse_pkg::CFG_W-1:0] size_reg,
                                              int unsigned limit);
      if (size_reg == '0) return 1;
      if (size_reg > limit) return limit;
      return int'(size_reg);
   endfunction

   class stats_scoreboard;
      logic [fse_pkg::CFG_W-1:0]  width_reg = fse_pkg::WIDTH_RESET;
      logic [fse_pkg::CFG_W-1:0]  height_reg = fse_pkg::HEIGHT_RESET;
      int unsigned                col;
      int unsigned                row;
      logic [fse_pkg::PIX_W-1:0]  lowest;
      logic [fse_pkg::PIX_W-1:0]  highest;
      logic [fse_pkg::SUM_W-1:0]  total;
      logic [fse_pkg::HASH_W-1:0] hash;
      logic [fse_pkg::CNT_W-1:0]  nonzero;
      logic [fse_pkg::CNT_W-1:0]  bright;
      logic [fse_pkg::CNT_W-1:0]  border;
      logic [fse_pkg::CNT_W-1:0]  interior;
      frame_stats_type            expected_frames[$];
      int unsigned                mismatches;

      function new();
         clear_frame();
      endfunction

      function void clear_frame();
         col = 0;
         row = 0;
         lowest = fse_pkg::PIX_MAX;
         highest = '0;
         total = '0;
         hash = fse_pkg::HASH_BASIS;
         nonzero = '0;
         bright = '0;
         border = '0;
         interior = '0;
      endfunction

      function void set_register(logic [fse_pkg::CSR_IDX_W-1:0] index,
                                 logic [fse_pkg::CFG_W-1:0] value);
         case (index)
            fse_pkg::REG_FRAME_WIDTH: width_reg = value;
            fse_pkg::REG_FRAME_HEIGHT: height_reg = value;
            default: ;
         endcase
      endfunction

      function bit mid_frame();
         return col != 0 || row != 0;
      endfunction

      function void take_pixel(logic [fse_pkg::PIX_W-1:0] pix);
         int unsigned     w;
         int unsigned     h;
         int unsigned     avg;
         bit              on_border;
         frame_stats_type stats;
         w = clamp_size(width_reg, fse_pkg::DEF_MAX_WIDTH);
         h = clamp_size(height_reg, fse_pkg::DEF_MAX_HEIGHT);
         on_border = col < MARGIN || row < MARGIN || col + MARGIN >= w || row + MARGIN >= h;
         if (pix < lowest) lowest = pix;
         if (pix > highest) highest = pix;
         total = total + fse_pkg::SUM_W'(pix);
         hash = (hash ^ 32'(pix)) * fse_pkg::HASH_PRIME;
         if (pix != '0) begin
            nonzero = nonzero + fse_pkg::CNT_W'(1);
            if (on_border) border = border + fse_pkg::CNT_W'(1);
            else interior = interior + fse_pkg::CNT_W'(1);
         end
         if (pix >= fse_pkg::BRIGHT_LEVEL) bright = bright + fse_pkg::CNT_W'(1);
         if (col + 1 < w) begin
            col++;
         end else if (row + 1 < h) begin
            col = 0;
            row++;
         end else begin
            avg = int'(total) / (w * h);
            stats.min_value = lowest;
            stats.max_value = highest;
            stats.mean_value = (avg > fse_pkg::PIX_MAX) ? fse_pkg::PIX_MAX
                                                        : avg[fse_pkg::PIX_W-1:0];
            stats.nonzero_count = nonzero;
            stats.bright_count = bright;
            stats.border_nonzero_count = border;
            stats.interior_nonzero_count = interior;
            stats.fnv_checksum = hash;
            expected_frames.push_back(stats);
            clear_frame();
         end
      endfunction

      function void compare(string field, longint unsigned want, longint unsigned got);
         if (want != got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: %s mismatch, expected %0d (0x%0h), got %0d (0x%0h)",
                        $realtime, field, want, want, got, got);
         end
      endfunction

      function void check_frame(frame_stats_type got);
         frame_stats_type want;
         if (expected_frames.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: result beat with no frame outstanding, checksum 0x%0h",
                        $realtime, got.fnv_checksum);
            return;
         end
         want = expected_frames.pop_front();
         compare("min_value", 64'(want.min_value), 64'(got.min_value));
         compare("max_value", 64'(want.max_value), 64'(got.max_value));
         compare("mean_value", 64'(want.mean_value), 64'(got.mean_value));
         compare("nonzero_count", 64'(want.nonzero_count), 64'(got.nonzero_count));
         compare("bright_count", 64'(want.bright_count), 64'(got.bright_count));
         compare("border_nonzero_count", 64'(want.border_nonzero_count),
                 64'(got.border_nonzero_count));
         compare("interior_nonzero_count", 64'(want.interior_nonzero_count),
                 64'(got.interior_nonzero_count));
         compare("fnv_checksum", 64'(want.fnv_checksum), 64'(got.fnv_checksum));
      endfunction
   endclass

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic [fse_pkg::PIX_W-1:0]     req_pixel;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic [fse_pkg::PIX_W-1:0]     rsp_min_value;
   logic [fse_pkg::PIX_W-1:0]     rsp_max_value;
   logic [fse_pkg::PIX_W-1:0]     rsp_mean_value;
   logic [fse_pkg::CNT_W-1:0]     rsp_nonzero_count;
   logic [fse_pkg::CNT_W-1:0]     rsp_bright_count;
   logic [fse_pkg::CNT_W-1:0]     rsp_border_nonzero_count;
   logic [fse_pkg::CNT_W-1:0]     rsp_interior_nonzero_count;
   logic [fse_pkg::HASH_W-1:0]    rsp_fnv_checksum;
   logic                          csr_valid;
   logic                          csr_ready;
   logic [fse_pkg::CSR_IDX_W-1:0] csr_index;
   logic [fse_pkg::CFG_W-1:0]     csr_wdata;

   stats_scoreboard sb;
   frame_stats_type observed;
   int unsigned     pixels_sent;
   int              burst_left;
   int              idle_left;
   bit              steady_sender;
   bit              hold_off_request;
   int              hold_off_left;
   int              stall_run;
   int              stall_pct;
   int unsigned     quiet_cycles;

   frame_statistics_engine dut (
      .clock                      (clock),
      .reset                      (reset),
      .req_valid                  (req_valid),
      .req_stall                  (req_stall),
      .req_pixel                  (req_pixel),
      .rsp_valid                  (rsp_valid),
      .rsp_stall                  (rsp_stall),
      .rsp_min_value              (rsp_min_value),
      .rsp_max_value              (rsp_max_value),
      .rsp_mean_value             (rsp_mean_value),
      .rsp_nonzero_count          (rsp_nonzero_count),
      .rsp_bright_count           (rsp_bright_count),
      .rsp_border_nonzero_count   (rsp_border_nonzero_count),
      .rsp_interior_nonzero_count (rsp_interior_nonzero_count),
      .rsp_fnv_checksum           (rsp_fnv_checksum),
      .csr_valid                  (csr_valid),
      .csr_ready                  (csr_ready),
      .csr_index                  (csr_index),
      .csr_wdata                  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [fse_pkg::PIX_W-1:0] pick_pixel(fill_type fill);
      case (fill)
         FILL_NOISE: return fse_pkg::PIX_W'($urandom_range(0, 255));
         FILL_SPARSE: return ($urandom_range(0, 3) == 0) ?
                             fse_pkg::PIX_W'($urandom_range(1, 255)) : '0;
         FILL_BRIGHT: return ($urandom_range(0, 3) == 0) ?
                             fse_pkg::PIX_W'($urandom_range(0, 127)) :
                             fse_pkg::PIX_W'($urandom_range(128, 255));
         FILL_WHITE: return fse_pkg::PIX_MAX;
         default: return '0;
      endcase
   endfunction

   task automatic send_pixel(input logic [fse_pkg::PIX_W-1:0] pix);
      while (idle_left > 0) begin
         req_valid <= 1'b0;
         @(posedge clock);
         idle_left--;
      end
      req_valid <= 1'b1;
      req_pixel <= pix;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.take_pixel(pix);
      pixels_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(1, 40);
         idle_left = steady_sender ? 0 : $urandom_range(1, 6);
      end
   endtask

   task automatic send_pixels(input int unsigned count);
      fill_type fill;
      fill = fill_type'($urandom_range(0, 4));
      repeat (count) send_pixel(pick_pixel(fill));
   endtask

   task automatic write_register(input logic [fse_pkg::CSR_IDX_W-1:0] index,
                                 input logic [fse_pkg::CFG_W-1:0] value, input bit more);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_register(index, value);
      if (!more) csr_valid <= 1'b0;
   endtask

   task automatic settle_block();
      req_valid <= 1'b0;
      while (sb.expected_frames.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic pick_size(input bit oversize, output logic [fse_pkg::CFG_W-1:0] w,
                            output logic [fse_pkg::CFG_W-1:0] h);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (oversize) begin
         w = fse_pkg::CFG_W'($urandom_range(fse_pkg::DEF_MAX_WIDTH + 1, 2047));
         h = fse_pkg::CFG_W'($urandom_range(0, 1));
         if ($urandom_range(0, 1) == 1) begin
            h = w;
            w = fse_pkg::CFG_W'($urandom_range(0, 1));
         end
      end else if (roll < 55) begin
         w = fse_pkg::CFG_W'($urandom_range(0, 8));
         h = fse_pkg::CFG_W'($urandom_range(0, 8));
      end else if (roll < 80) begin
         w = fse_pkg::CFG_W'($urandom_range(1, 48));
         h = fse_pkg::CFG_W'($urandom_range(1, 3));
         if ($urandom_range(0, 1) == 1) begin
            h = w;
            w = fse_pkg::CFG_W'($urandom_range(1, 3));
         end
      end else begin
         w = fse_pkg::CFG_W'($urandom_range(17, 24));
         h = fse_pkg::CFG_W'($urandom_range(17, 20));
      end
   endtask

   always @(posedge clock) begin
      if (hold_off_request) begin
         hold_off_left = HOLD_OFF_CYCLES;
         hold_off_request = 1'b0;
      end
      if (hold_off_left > 0) begin
         hold_off_left--;
         rsp_stall <= 1'b1;
      end else begin
         if (stall_run == 0) begin
            stall_run = $urandom_range(4, 60);
            case ($urandom_range(0, 4))
               0, 1: stall_pct = 0;
               2: stall_pct = 25;
               3: stall_pct = 50;
               default: stall_pct = 90;
            endcase
         end
         stall_run--;
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         observed.min_value = rsp_min_value;
         observed.max_value = rsp_max_value;
         observed.mean_value = rsp_mean_value;
         observed.nonzero_count = rsp_nonzero_count;
         observed.bright_count = rsp_bright_count;
         observed.border_nonzero_count = rsp_border_nonzero_count;
         observed.interior_nonzero_count = rsp_interior_nonzero_count;
         observed.fnv_checksum = rsp_fnv_checksum;
         sb.check_frame(observed);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("frame_statistics_engine_tb: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [fse_pkg::CFG_W-1:0] w;
      logic [fse_pkg::CFG_W-1:0] h;
      int unsigned               phase;
      int unsigned               frame_pixels;
      int unsigned               frames;
      sb = new;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_pixel <= '0;
      rsp_stall <= 1'b0;
      csr_valid <= 1'b0;
      csr_index <= fse_pkg::REG_FRAME_WIDTH;
      csr_wdata <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // zero width reads as one column
      write_register(fse_pkg::REG_FRAME_WIDTH, '0, 1'b1);
      write_register(fse_pkg::REG_FRAME_HEIGHT, 11'd3, 1'b0);
      send_pixel(8'd0);
      send_pixel(fse_pkg::PIX_MAX);
      send_pixel(fse_pkg::BRIGHT_LEVEL);
      settle_block();

      // unused indexes must leave the size alone
      write_register(REG_SPARE0, '1, 1'b1);
      write_register(REG_SPARE1, '0, 1'b0);
      send_pixel(fse_pkg::BRIGHT_LEVEL - 8'd1);
      send_pixel(8'd1);
      send_pixel(fse_pkg::PIX_MAX - 8'd1);
      settle_block();

      // shrink mid-frame so the frame ends at once and the mean saturates
      write_register(fse_pkg::REG_FRAME_WIDTH, 11'd4, 1'b1);
      write_register(fse_pkg::REG_FRAME_HEIGHT, 11'd4, 1'b0);
      repeat (12) send_pixel(fse_pkg::PIX_MAX);
      settle_block();
      write_register(fse_pkg::REG_FRAME_WIDTH, 11'd1, 1'b1);
      write_register(fse_pkg::REG_FRAME_HEIGHT, 11'd1, 1'b0);
      send_pixel(fse_pkg::PIX_MAX);

      phase = 0;
      pixels_sent = 0;
      while (pixels_sent < RANDOM_PIXELS) begin
         settle_block();
         steady_sender = ($urandom_range(0, 3) == 0);
         if (phase == 2 || $urandom_range(0, 19) == 0) begin
            write_register(fse_pkg::REG_FRAME_WIDTH, 11'd2, 1'b1);
            write_register(fse_pkg::REG_FRAME_HEIGHT, 11'd2, 1'b0);
            hold_off_request = 1'b1;
            steady_sender = 1'b1;
            repeat (10) send_pixels(4);
         end else begin
            pick_size(phase == 0 || $urandom_range(0, 49) == 0, w, h);
            if ($urandom_range(0, 6) == 0) begin
               write_register($urandom_range(0, 1) ? fse_pkg::REG_FRAME_WIDTH
                                                   : fse_pkg::REG_FRAME_HEIGHT,
                              $urandom_range(0, 1) ? w : h, 1'b0);
            end else begin
               write_register(fse_pkg::REG_FRAME_WIDTH, w, 1'b1);
               write_register(fse_pkg::REG_FRAME_HEIGHT, h, 1'b0);
            end
            frame_pixels = clamp_size(sb.width_reg, fse_pkg::DEF_MAX_WIDTH) *
                           clamp_size(sb.height_reg, fse_pkg::DEF_MAX_HEIGHT);
            if ($urandom_range(0, 9) == 0) begin
               send_pixels($urandom_range(1, frame_pixels));
               settle_block();
               pick_size(1'b0, w, h);
               write_register(fse_pkg::REG_FRAME_WIDTH, w, 1'b1);
               write_register(fse_pkg::REG_FRAME_HEIGHT, h, 1'b0);
               while (sb.mid_frame()) send_pixel(pick_pixel(FILL_NOISE));
            end else begin
               frames = (frame_pixels > BIG_FRAME) ? 1 : $urandom_range(1, 3);
               repeat (frames) begin
                  if (pixels_sent < RANDOM_PIXELS) send_pixels(frame_pixels);
               end
            end
         end
         phase++;
      end

      settle_block();
      if (sb.mismatches == 0 && sb.expected_frames.size() == 0)
         $display("frame_statistics_engine_tb: done, clean");
      else
         $display("frame_statistics_engine_tb: done, errors");
      $finish;
   end

endmodule

// ===== frame_statistics_engine.f =====
src/fse_pkg.sv
src/fse_div.sv
src/fse_dp.sv
src/fse_ctrl.sv
src/frame_statistics_engine.sv
test/frame_statistics_engine_tb.sv
